/* hdl/pmcom_pkg.sv */
// ----------------------------------------------------------------------------
// pmcom_pkg
// Shared types and codes for the polygon masked color outlier marker.
// ----------------------------------------------------------------------------
package pmcom_pkg;

    localparam logic [1:0] MODE_VERTEX = 2'd0;
    localparam logic [1:0] MODE_COLOR  = 2'd1;
    localparam logic [1:0] MODE_PIXEL  = 2'd2;

    localparam logic [2:0] REG_ENTRY_COUNT = 3'd0;
    localparam logic [2:0] REG_LIMIT       = 3'd1;
    localparam logic [2:0] REG_TOLERANCES  = 3'd2;
    localparam logic [2:0] REG_ROW_START   = 3'd3;
    localparam logic [2:0] REG_ROW_END     = 3'd4;
    localparam logic [2:0] REG_COL_START   = 3'd5;
    localparam logic [2:0] REG_COL_END     = 3'd6;

    typedef struct packed {
        logic             valid;
        logic             test;
        logic [1:0]       mode;
        logic [5:0]       idx;
        logic [15:0]      vx;
        logic [15:0]      vy;
        logic [23:0]      color;
        logic [11:0]      row;
        logic [11:0]      col;
        logic [2:0][9:0]  blend;
        logic [15:0]      v0x;
        logic [15:0]      v0y;
        logic             odd;
    } t_token;

endpackage

/* hdl/polygon_masked_color_outlier_mark_top.sv */
// ----------------------------------------------------------------------------
// polygon_masked_color_outlier_mark_top
// Marks pixels inside a polygon and a box whose blended color mismatches too
// many reference colors.
// ----------------------------------------------------------------------------
// Usage: every transaction on the slave stream (s_axis_*) yields exactly one
// transaction on the master stream (m_axis_*), in order. s_axis_tuser holds
// the mode: vertex load, reference color load or pixel. Loads are written
// into the cell whose index they carry as they pass along the chain.
// A transaction enters an input register, then walks a chain of MAX_ENTRIES
// cells, one cell per cycle while the chain advances, each cell testing one
// polygon edge and one reference color; a final register forms the result.
// One transaction per cycle is accepted while the chain is not held.
// The chain advances as a whole; when the result register is full and
// m_axis_tready is low, the whole chain holds and s_axis_tready drops.
// Reset empties the chain and sets the registers to their reset values;
// vertex and color stores are undefined until loaded. Configuration over APB
// must be written only while the chain is empty; the block does not check.
// ----------------------------------------------------------------------------
module polygon_masked_color_outlier_mark_top import pmcom_pkg::*; #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index, vertex_x, vertex_y, pixel_row, pixel_col, primary_red,
    // primary_green, primary_blue, secondary_red, secondary_green,
    // secondary_blue
    input  logic [111:0] s_axis_tdata,
    // mode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // marked, inside_polygon, mismatch_count
    output logic [15:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [6:0]  r_entry_count;
    logic [7:0]  r_limit;
    logic [23:0] r_tol;
    logic [11:0] r_row_start, r_col_start;
    logic [12:0] r_row_end, r_col_end;

    logic        adv, accept, wr;
    logic [2:0]  reg_idx;
    logic [NW-1:0] n_act;
    t_token      r_tok0, n_tok0;
    t_token      w_tok [0:MAX_ENTRIES];
    logic [CW-1:0] w_cnt [0:MAX_ENTRIES];
    logic [15:0] w_vx [0:MAX_ENTRIES-1];
    logic [15:0] w_vy [0:MAX_ENTRIES-1];

    logic        r_ovalid, r_marked, r_inside;
    logic [6:0]  r_count;
    logic        n_inside;
    logic [6:0]  n_count;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_limit       <= 8'd64;
            r_tol         <= '0;
            r_row_start   <= '0;
            r_row_end     <= '0;
            r_col_start   <= '0;
            r_col_end     <= '0;
        end else if (wr) begin
            unique case (reg_idx)
                REG_ENTRY_COUNT: r_entry_count <= pwdata[6:0];
                REG_LIMIT:       r_limit       <= pwdata[7:0];
                REG_TOLERANCES:  r_tol         <= pwdata[23:0];
                REG_ROW_START:   r_row_start   <= pwdata[11:0];
                REG_ROW_END:     r_row_end     <= pwdata[12:0];
                REG_COL_START:   r_col_start   <= pwdata[11:0];
                REG_COL_END:     r_col_end     <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ENTRY_COUNT: prdata = 32'(r_entry_count);
            REG_LIMIT:       prdata = 32'(r_limit);
            REG_TOLERANCES:  prdata = 32'(r_tol);
            REG_ROW_START:   prdata = 32'(r_row_start);
            REG_ROW_END:     prdata = 32'(r_row_end);
            REG_COL_START:   prdata = 32'(r_col_start);
            REG_COL_END:     prdata = 32'(r_col_end);
            default:         prdata = '0;
        endcase
    end

    assign n_act = (int'(r_entry_count) > MAX_ENTRIES) ? NW'(MAX_ENTRIES) : NW'(r_entry_count);

    assign adv           = !r_ovalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    always_comb begin
        n_tok0       = '0;
        n_tok0.valid = accept;
        n_tok0.mode  = s_axis_tuser;
        n_tok0.idx   = s_axis_tdata[5:0];
        n_tok0.vx    = s_axis_tdata[21:6];
        n_tok0.vy    = s_axis_tdata[37:22];
        n_tok0.row   = s_axis_tdata[49:38];
        n_tok0.col   = s_axis_tdata[61:50];
        n_tok0.color = s_axis_tdata[85:62];
        for (int c = 0; c < 3; c++) begin
            n_tok0.blend[c] = {1'b0, s_axis_tdata[62 + 8*c +: 8], 1'b0}
                            + 10'(s_axis_tdata[86 + 8*c +: 8]);
        end
        n_tok0.test = (s_axis_tuser == MODE_PIXEL)
                   && n_tok0.row >= r_row_start && {1'b0, n_tok0.row} < r_row_end
                   && n_tok0.col >= r_col_start && {1'b0, n_tok0.col} < r_col_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0.valid <= 1'b0;
        end else if (adv) begin
            r_tok0 <= n_tok0;
        end
    end

    assign w_tok[0] = r_tok0;
    assign w_cnt[0] = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [15:0] nx_x, nx_y;
        if (g < MAX_ENTRIES - 1) begin : g_mid
            assign nx_x = w_vx[g+1];
            assign nx_y = w_vy[g+1];
        end else begin : g_end
            assign nx_x = '0;
            assign nx_y = '0;
        end
        pmcom_cell #(
            .IDX (g),
            .NW  (NW),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_n     (n_act),
            .i_tol   (r_tol),
            .i_tok   (w_tok[g]),
            .i_cnt   (w_cnt[g]),
            .i_nx_x  (nx_x),
            .i_nx_y  (nx_y),
            .o_tok   (w_tok[g+1]),
            .o_cnt   (w_cnt[g+1]),
            .o_vx    (w_vx[g]),
            .o_vy    (w_vy[g])
        );
    end

    always_comb begin
        n_inside = w_tok[MAX_ENTRIES].test && w_tok[MAX_ENTRIES].odd;
        if (!n_inside) begin
            n_count = '0;
        end else if (int'(w_cnt[MAX_ENTRIES]) > 127) begin
            n_count = 7'd127;
        end else begin
            n_count = 7'(w_cnt[MAX_ENTRIES]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= w_tok[MAX_ENTRIES].valid;
            r_inside <= n_inside;
            r_count  <= n_count;
            r_marked <= n_inside && ($signed({1'b0, n_count}) > $signed(r_limit));
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_count, r_inside, r_marked};

endmodule

/* hdl/pmcom_cell.sv */
// ----------------------------------------------------------------------------
// pmcom_cell
// One chain cell: holds one vertex and one reference color, tests one polygon
// edge and one reference color against the passing transaction.
// ----------------------------------------------------------------------------
module pmcom_cell import pmcom_pkg::*; #(
    parameter int IDX = 0,
    parameter int NW  = 7,
    parameter int CW  = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic [NW-1:0] i_n,
    input  logic [23:0]   i_tol,
    input  t_token        i_tok,
    input  logic [CW-1:0] i_cnt,
    input  logic [15:0]   i_nx_x,
    input  logic [15:0]   i_nx_y,
    output t_token        o_tok,
    output logic [CW-1:0] o_cnt,
    output logic [15:0]   o_vx,
    output logic [15:0]   o_vy
);

    logic [15:0] r_vx, r_vy;
    logic [23:0] r_color;
    t_token      r_tok, n_tok;
    logic [CW-1:0] r_cnt;

    logic               active, last, fwd, cond, below, flip, mis;
    logic [15:0]        xi, yi, xj, yj, px, py, own0x, own0y;
    logic signed [16:0] d, dy, dx, ex;
    logic signed [33:0] lhs, rhs;
    logic [2:0]         ch_mis;

    always_comb begin
        active = i_tok.test && (IDX < int'(i_n));
        last   = (int'(i_n) == IDX + 1);
        // take the neighbor vertex from a load one slot ahead that has not landed yet
        fwd    = r_tok.valid && (r_tok.mode == MODE_VERTEX) && (int'(r_tok.idx) == IDX + 1);
        own0x  = (IDX == 0) ? r_vx : i_tok.v0x;
        own0y  = (IDX == 0) ? r_vy : i_tok.v0y;
        xi     = r_vx;
        yi     = r_vy;
        xj     = last ? own0x : (fwd ? r_tok.vx : i_nx_x);
        yj     = last ? own0y : (fwd ? r_tok.vy : i_nx_y);
        px     = {i_tok.row, 4'b0000};
        py     = {i_tok.col, 4'b0000};
        cond   = ((yi < py && yj >= py) || (yj < py && yi >= py)) && (xi <= px || xj <= px);
        d      = $signed({1'b0, yj}) - $signed({1'b0, yi});
        dy     = $signed({1'b0, py}) - $signed({1'b0, yi});
        dx     = $signed({1'b0, xj}) - $signed({1'b0, xi});
        ex     = $signed({1'b0, px}) - $signed({1'b0, xi});
        lhs    = dy * dx;
        rhs    = ex * d;
        below  = (d > 17'sd0) ? (lhs < rhs) : (lhs > rhs);
        flip   = active && cond && below;
        for (int c = 0; c < 3; c++) begin
            logic signed [10:0] diff;
            logic        [9:0]  r3, t3, mag;
            r3        = 10'(r_color[8*c +: 8]) * 10'd3;
            t3        = 10'(i_tol[8*c +: 8]) * 10'd3;
            diff      = $signed({1'b0, i_tok.blend[c]}) - $signed({1'b0, r3});
            mag       = diff[10] ? 10'(-diff) : diff[9:0];
            ch_mis[c] = mag > t3;
        end
        mis   = active && (|ch_mis);
        n_tok = i_tok;
        n_tok.v0x = own0x;
        n_tok.v0y = own0y;
        n_tok.odd = i_tok.odd ^ flip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
            r_cnt <= i_cnt + CW'(mis);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_tok.valid && int'(i_tok.idx) == IDX) begin
            if (i_tok.mode == MODE_VERTEX) begin
                r_vx <= i_tok.vx;
                r_vy <= i_tok.vy;
            end
            if (i_tok.mode == MODE_COLOR) begin
                r_color <= i_tok.color;
            end
        end
    end

    assign o_tok = r_tok;
    assign o_cnt = r_cnt;
    assign o_vx  = r_vx;
    assign o_vy  = r_vy;

endmodule

/* dv/polygon_masked_color_outlier_mark_top_test.sv */
// ----------------------------------------------------------------------------
// polygon_masked_color_outlier_mark_top_test
// Self-checking bench for the polygon masked color outlier marker. Loads fill
// the vertex and color stores, pixel transactions are scored against an
// in-bench predictor, and a queue of expected results is matched against the
// master stream in order while both sides idle in random bursts.
// ----------------------------------------------------------------------------
module polygon_masked_color_outlier_mark_top_test;
    import pmcom_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 64;
    localparam int TIMEOUT = 400000;

    typedef struct {
        logic [1:0]  mode;
        logic [5:0]  idx;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [11:0] row;
        logic [11:0] col;
        logic [7:0]  pr, pg, pb, sr, sg, sb;
    } pix_item_t;

    typedef struct {
        logic       marked;
        logic       in_poly;
        logic [6:0] count;
    } mark_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [15:0]  m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    polygon_masked_color_outlier_mark_top uut (.*);

    pix_item_t item_q[$];
    mark_t     mark_q[$];
    int        errors = 0;
    int        cycles = 0;
    bit        quiet = 0;
    bit        hold_req = 0;
    int        hold_cnt = 0;
    int        src_gap = 0;
    int        snk_gap = 0;

    logic [6:0]  cfg_count;
    logic [7:0]  cfg_limit;
    logic [23:0] cfg_tol;
    logic [11:0] cfg_row_lo, cfg_col_lo;
    logic [12:0] cfg_row_hi, cfg_col_hi;
    logic [15:0] vx_mem[NSLOT];
    logic [15:0] vy_mem[NSLOT];
    logic [23:0] ref_mem[NSLOT];

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int live_entries();
        return (cfg_count > NSLOT) ? NSLOT : int'(cfg_count);
    endfunction

    function automatic bit in_polygon(longint px, longint py);
        int n;
        int j;
        bit odd;
        longint xi, yi, xj, yj, d, lhs, rhs;
        bit below;
        n = live_entries();
        odd = 0;
        if (n == 0) return 0;
        j = n - 1;
        for (int i = 0; i < n; i++) begin
            xi = vx_mem[i]; yi = vy_mem[i];
            xj = vx_mem[j]; yj = vy_mem[j];
            if (((yi < py && yj >= py) || (yj < py && yi >= py)) &&
                (xi <= px || xj <= px)) begin
                d = yj - yi;
                lhs = (py - yi) * (xj - xi);
                rhs = (px - xi) * d;
                below = (d > 0) ? (lhs < rhs) : (lhs > rhs);
                if (below) odd = ~odd;
            end
            j = i;
        end
        return odd;
    endfunction

    function automatic bit chan_off(int blend3, int refc, int tol);
        int diff;
        diff = blend3 - 3 * refc;
        if (diff < 0) diff = -diff;
        return diff > 3 * tol;
    endfunction

    function automatic mark_t score_item(pix_item_t it);
        mark_t r;
        int cnt;
        int br, bg, bb;
        logic [23:0] c;
        r = '{1'b0, 1'b0, 7'd0};
        case (it.mode)
            MODE_VERTEX: begin
                vx_mem[it.idx] = it.vx;
                vy_mem[it.idx] = it.vy;
            end
            MODE_COLOR: ref_mem[it.idx] = {it.pb, it.pg, it.pr};
            MODE_PIXEL: begin
                if (it.row >= cfg_row_lo && it.row < cfg_row_hi &&
                    it.col >= cfg_col_lo && it.col < cfg_col_hi) begin
                    r.in_poly = in_polygon(longint'(it.row) * 16, longint'(it.col) * 16);
                    if (r.in_poly) begin
                        br = 2 * it.pr + it.sr;
                        bg = 2 * it.pg + it.sg;
                        bb = 2 * it.pb + it.sb;
                        cnt = 0;
                        for (int k = 0; k < live_entries(); k++) begin
                            c = ref_mem[k];
                            if (chan_off(br, c[7:0], cfg_tol[7:0]) ||
                                chan_off(bg, c[15:8], cfg_tol[15:8]) ||
                                chan_off(bb, c[23:16], cfg_tol[23:16]))
                                cnt++;
                        end
                        r.count = cnt[6:0];
                        r.marked = (cnt > int'($signed(cfg_limit)));
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // source side
    always @(posedge i_clk) begin
        logic nv;
        pix_item_t it;
        if (i_rst_n) begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                mark_q.push_back(score_item(item_q.pop_front()));
                nv = 1'b0;
            end
            if (!nv) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                end else if (item_q.size() > 0) begin
                    if (!quiet && $urandom_range(0, 7) == 0) begin
                        src_gap <= $urandom_range(1, 10);
                    end else begin
                        it = item_q[0];
                        nv = 1'b1;
                        s_axis_tuser <= it.mode;
                        s_axis_tdata <= {2'b00, it.sb, it.sg, it.sr, it.pb, it.pg, it.pr,
                                         it.col, it.row, it.vy, it.vx, it.idx};
                    end
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // sink side
    always @(posedge i_clk) begin
        mark_t e;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (mark_q.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    e = mark_q.pop_front();
                    if (m_axis_tdata[0] !== e.marked) begin
                        $display("%0t marked: expected %0d actual %0d",
                                 $time, e.marked, m_axis_tdata[0]);
                        errors++;
                    end
                    if (m_axis_tdata[1] !== e.in_poly) begin
                        $display("%0t inside_polygon: expected %0d actual %0d",
                                 $time, e.in_poly, m_axis_tdata[1]);
                        errors++;
                    end
                    if (m_axis_tdata[8:2] !== e.count) begin
                        $display("%0t mismatch_count: expected %0d actual %0d",
                                 $time, e.count, m_axis_tdata[8:2]);
                        errors++;
                    end
                end
            end
            if (hold_req && hold_cnt < 300) begin
                hold_cnt <= hold_cnt + 1;
                m_axis_tready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                snk_gap <= $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic reg_write(logic [2:0] ri, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {ri, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (ri)
            REG_ENTRY_COUNT: cfg_count = val[6:0];
            REG_LIMIT:       cfg_limit = val[7:0];
            REG_TOLERANCES:  cfg_tol = val[23:0];
            REG_ROW_START:   cfg_row_lo = val[11:0];
            REG_ROW_END:     cfg_row_hi = val[12:0];
            REG_COL_START:   cfg_col_lo = val[11:0];
            REG_COL_END:     cfg_col_hi = val[12:0];
            default: ;
        endcase
    endtask

    task automatic set_all(int n, int lim, logic [23:0] tol,
                           int rl, int rh, int cl, int ch);
        reg_write(REG_ENTRY_COUNT, n);
        reg_write(REG_LIMIT, lim & 8'hff);
        reg_write(REG_TOLERANCES, tol);
        reg_write(REG_ROW_START, rl);
        reg_write(REG_ROW_END, rh);
        reg_write(REG_COL_START, cl);
        reg_write(REG_COL_END, ch);
    endtask

    task automatic drain();
        while (item_q.size() > 0 || mark_q.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic pix_item_t noise_item();
        pix_item_t it;
        it.mode = $urandom_range(0, 3);
        it.idx = $urandom; it.vx = $urandom; it.vy = $urandom;
        it.row = $urandom; it.col = $urandom;
        it.pr = $urandom; it.pg = $urandom; it.pb = $urandom;
        it.sr = $urandom; it.sg = $urandom; it.sb = $urandom;
        return it;
    endfunction

    function automatic logic [7:0] near8(logic [7:0] base, int span);
        int v;
        v = int'(base) + $urandom_range(0, 2 * span) - span;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic pix_item_t pixel_at(int row, int col, logic [23:0] bc);
        pix_item_t it;
        it = noise_item();
        it.mode = MODE_PIXEL;
        it.row = row; it.col = col;
        it.pr = near8(bc[7:0], 24); it.pg = near8(bc[15:8], 24);
        it.pb = near8(bc[23:16], 24);
        it.sr = near8(bc[7:0], 24); it.sg = near8(bc[15:8], 24);
        it.sb = near8(bc[23:16], 24);
        return it;
    endfunction

    task automatic load_shape(int n, int cx, int cy, int rad, logic [23:0] bc);
        pix_item_t it;
        for (int i = 0; i < n && i < NSLOT; i++) begin
            it = noise_item();
            it.mode = MODE_VERTEX; it.idx = i;
            it.vx = (cx - rad) * 16 + $urandom_range(0, 32 * rad);
            it.vy = (cy - rad) * 16 + $urandom_range(0, 32 * rad);
            item_q.push_back(it);
            it = noise_item();
            it.mode = MODE_COLOR; it.idx = i;
            it.pr = near8(bc[7:0], 30); it.pg = near8(bc[15:8], 30);
            it.pb = near8(bc[23:16], 30);
            item_q.push_back(it);
        end
    endtask

    initial begin
        pix_item_t it;
        int n, cx, cy, rad, lim, sel;
        logic [23:0] bc;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 4; i++) begin
            it = noise_item(); it.mode = MODE_VERTEX; it.idx = i; item_q.push_back(it);
            it = noise_item(); it.mode = MODE_COLOR;  it.idx = i; item_q.push_back(it);
        end
        drain();

        // square polygon around rows and columns 100..200
        set_all(4, 0, 24'h000000, 0, 4096, 0, 4096);
        for (int i = 0; i < 4; i++) begin
            it = noise_item(); it.mode = MODE_VERTEX; it.idx = i;
            it.vx = (i == 0 || i == 3) ? 16'd1600 : 16'd3200;
            it.vy = (i < 2) ? 16'd1600 : 16'd3200;
            item_q.push_back(it);
        end
        it = pixel_at(150, 150, 24'h808080);
        it.pr = 8'hff; it.pg = 8'hff; it.pb = 8'hff;
        it.sr = 8'hff; it.sg = 8'hff; it.sb = 8'hff;
        item_q.push_back(it);
        it.pr = 0; it.pg = 0; it.pb = 0; it.sr = 0; it.sg = 0; it.sb = 0;
        item_q.push_back(it);
        item_q.push_back(pixel_at(100, 100, 24'h808080));
        item_q.push_back(pixel_at(200, 150, 24'h808080));
        item_q.push_back(pixel_at(4095, 4095, 24'h808080));
        item_q.push_back(pixel_at(0, 0, 24'h808080));
        it = noise_item(); it.mode = 2'd3; it.idx = '1; it.vx = '1; item_q.push_back(it);
        it = noise_item(); it.mode = MODE_VERTEX; it.idx = 63;
        it.vx = 16'hffff; it.vy = 16'h0000; item_q.push_back(it);
        it = noise_item(); it.mode = MODE_COLOR; it.idx = 63;
        it.pr = 8'hff; it.pg = 8'hff; it.pb = 8'hff; item_q.push_back(it);
        item_q.push_back(pixel_at(150, 150, 24'h808080));
        drain();

        for (int p = 0; p < 10; p++) begin
            n = $urandom_range(3, 20);
            lim = $urandom_range(0, 20);
            cx = $urandom_range(100, 3900);
            cy = $urandom_range(100, 3900);
            rad = $urandom_range(4, 60);
            bc = $urandom;
            case (p)
                0: set_all(0, 64, 24'hffffff, 0, 4096, 0, 4096);
                1: set_all(64, -1, 24'h000000, 0, 4096, 0, 4096);
                2: set_all(127, 64, 24'h0a0a0a, 0, 4096, 0, 4096);
                3: set_all(n, lim, $urandom_range(0, 15) * 24'h010101,
                           cx - rad / 2, cx + rad / 2, 0, 4096);
                4: set_all(n, lim, $urandom & 24'h0f0f0f, cx, cx, 0, 4096);
                5: set_all(n, lim, $urandom & 24'h0f0f0f, 4095, 0, 4095, 0);
                default: set_all(n, lim, $urandom & 24'h1f1f1f, cx - rad, cx + rad,
                                 cy - rad, cy + rad);
            endcase
            if (p == 1) hold_req = 1;
            if (p == 9) quiet = 1;
            load_shape((cfg_count > NSLOT) ? NSLOT : cfg_count, cx, cy, rad, bc);
            for (int k = 0; k < 12; k++) begin
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    item_q.push_back(pixel_at(cx + $urandom_range(0, 2 * rad) - rad,
                                              cy + $urandom_range(0, 2 * rad) - rad, bc));
                else if (sel == 7)
                    item_q.push_back(pixel_at($urandom, $urandom, bc));
                else
                    item_q.push_back(noise_item());
            end
            drain();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
